/* src/rrcd_pkg.sv */
package rrcd_pkg;

    // Longest RTP packet before it is closed without a chunk end.
    localparam int unsigned MAX_RTP_BYTES = 1024;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [6:0] RTP_PAYLOAD_TYPE = 7'd96;
    localparam logic [7:0] RTCP_SR_TYPE     = 8'd200;

    typedef enum logic [2:0] {
        KIND_RTP     = 3'd0,
        KIND_RTCP    = 3'd1,
        KIND_END     = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_TRUNC   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CLS_AWAIT = 2'd0,
        CLS_RTP   = 2'd1,
        CLS_RTCP  = 2'd2
    } pclass_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] timestamp;
        logic [15:0] seq_number;
        logic        marker_bit;
        logic [31:0] report_count;
        logic [18:0] packet_bytes;
    } rec_t;

    // Everything one input byte causes: an optional packet record and an
    // optional end-of-chunk record.
    typedef struct packed {
        logic        pkt_valid;
        rec_t        pkt;
        logic        end_valid;
        logic [31:0] end_timestamp;
        logic [15:0] end_seq_number;
    } entry_t;

endpackage

/* src/rrcd_front.sv */
module rrcd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            push,
    output rrcd_pkg::entry_t push_data
);
    import rrcd_pkg::*;

    logic [17:0] pos_reg, pos_next;
    pclass_t     class_reg, class_next;
    logic [31:0] ts_reg, ts_next;
    logic [15:0] seq_reg, seq_next;
    logic        mk_reg, mk_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] last_ts_reg, last_ts_next;
    logic [15:0] last_seq_reg, last_seq_next;
    logic        discard_reg, discard_next;

    logic        accept;
    logic [18:0] consumed;
    logic [18:0] rtcp_total;
    logic [16:0] len_plus;
    logic [7:0]  b;
    entry_t      ent;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign consumed = {1'b0, pos_reg} + 19'd1;

    always_comb begin
        pos_next      = pos_reg;
        class_next    = class_reg;
        ts_next       = ts_reg;
        seq_next      = seq_reg;
        mk_next       = mk_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        last_ts_next  = last_ts_reg;
        last_seq_next = last_seq_reg;
        discard_next  = discard_reg;
        ent           = '0;
        len_plus      = '0;
        rtcp_total    = '0;

        if (!discard_reg) begin
            if (pos_reg == 18'd0) begin
                ts_next    = '0;
                seq_next   = '0;
                mk_next    = 1'b0;
                cnt_next   = '0;
                len_next   = '0;
                class_next = CLS_AWAIT;
                if (s_tlast) begin
                    // A chunk that stops after one byte never shows its type.
                    ent.pkt_valid        = 1'b1;
                    ent.pkt.kind         = KIND_UNKNOWN;
                    ent.pkt.packet_bytes = 19'd1;
                end else begin
                    pos_next = 18'd1;
                end
            end else if (pos_reg == 18'd1 && b[6:0] != RTP_PAYLOAD_TYPE
                         && b != RTCP_SR_TYPE) begin
                ent.pkt_valid        = 1'b1;
                ent.pkt.kind         = KIND_UNKNOWN;
                ent.pkt.packet_bytes = 19'd2;
                pos_next             = '0;
                class_next           = CLS_AWAIT;
                discard_next         = 1'b1;
            end else begin
                if (pos_reg == 18'd1) begin
                    if (b[6:0] == RTP_PAYLOAD_TYPE) begin
                        class_next = CLS_RTP;
                        mk_next    = b[7];
                    end else begin
                        class_next = CLS_RTCP;
                    end
                end else if (class_reg == CLS_RTP) begin
                    if (pos_reg == 18'd2 || pos_reg == 18'd3) begin
                        seq_next = {seq_reg[7:0], b};
                    end else if (pos_reg >= 18'd4 && pos_reg <= 18'd7) begin
                        ts_next = {ts_reg[23:0], b};
                    end
                end else begin
                    if (pos_reg == 18'd2 || pos_reg == 18'd3) begin
                        len_next = {len_reg[7:0], b};
                    end else if (pos_reg >= 18'd16 && pos_reg <= 18'd19) begin
                        ts_next = {ts_reg[23:0], b};
                    end else if (pos_reg >= 18'd20 && pos_reg <= 18'd23) begin
                        cnt_next = {cnt_reg[23:0], b};
                    end
                end

                pos_next = consumed[17:0];
                if (class_next == CLS_RTP) begin
                    if (consumed == 19'(MAX_RTP_BYTES) || s_tlast) begin
                        ent.pkt_valid        = 1'b1;
                        ent.pkt.kind         = KIND_RTP;
                        ent.pkt.timestamp    = ts_next;
                        ent.pkt.seq_number   = seq_next;
                        ent.pkt.marker_bit   = mk_next;
                        ent.pkt.packet_bytes = consumed;
                        last_ts_next         = ts_next;
                        last_seq_next        = seq_next;
                        pos_next             = '0;
                        class_next           = CLS_AWAIT;
                    end
                end else begin
                    len_plus   = {1'b0, len_next} + 17'd1;
                    rtcp_total = {len_plus, 2'b00};
                    if (pos_reg >= 18'd3 && consumed == rtcp_total) begin
                        ent.pkt_valid = 1'b1;
                        ent.pkt.kind  = KIND_RTCP;
                    end else if (s_tlast) begin
                        ent.pkt_valid = 1'b1;
                        ent.pkt.kind  = KIND_TRUNC;
                    end
                    if (ent.pkt_valid) begin
                        ent.pkt.timestamp    = ts_next;
                        ent.pkt.report_count = cnt_next;
                        ent.pkt.packet_bytes = consumed;
                        pos_next             = '0;
                        class_next           = CLS_AWAIT;
                    end
                end
            end
        end

        if (s_tlast) begin
            ent.end_valid      = 1'b1;
            ent.end_timestamp  = last_ts_next;
            ent.end_seq_number = last_seq_next;
            last_ts_next       = '0;
            last_seq_next      = '0;
            discard_next       = 1'b0;
            pos_next           = '0;
            class_next         = CLS_AWAIT;
        end
    end

    assign push      = accept && (ent.pkt_valid || ent.end_valid);
    assign push_data = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            class_reg    <= CLS_AWAIT;
            ts_reg       <= '0;
            seq_reg      <= '0;
            mk_reg       <= 1'b0;
            cnt_reg      <= '0;
            len_reg      <= '0;
            last_ts_reg  <= '0;
            last_seq_reg <= '0;
            discard_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            class_reg    <= class_next;
            ts_reg       <= ts_next;
            seq_reg      <= seq_next;
            mk_reg       <= mk_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            last_ts_reg  <= last_ts_next;
            last_seq_reg <= last_seq_next;
            discard_reg  <= discard_next;
        end
    end

endmodule

/* src/rrcd_queue.sv */
module rrcd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rrcd_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output rrcd_pkg::entry_t pop_data
);
    import rrcd_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/rrcd_back.sv */
module rrcd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  rrcd_pkg::entry_t q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output rrcd_pkg::rec_t   m_rec,
    output logic             m_last
);
    import rrcd_pkg::*;

    logic   valid_reg, valid_next;
    logic   phase_reg, phase_next;
    rec_t   rec_reg, rec_next;
    logic   last_reg, last_next;
    logic   load;

    assign load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        rec_next   = rec_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = q_valid;
            if (q_valid) begin
                if (q_data.pkt_valid && !phase_reg) begin
                    rec_next  = q_data.pkt;
                    last_next = !q_data.end_valid;
                    if (q_data.end_valid) begin
                        phase_next = 1'b1;
                    end else begin
                        q_pop = 1'b1;
                    end
                end else begin
                    rec_next            = '0;
                    rec_next.kind       = KIND_END;
                    rec_next.timestamp  = q_data.end_timestamp;
                    rec_next.seq_number = q_data.end_seq_number;
                    last_next           = 1'b1;
                    phase_next          = 1'b0;
                    q_pop               = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg  <= rec_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_rec    = rec_reg;
    assign m_last   = last_reg;

endmodule

/* src/rtp_rtcp_chunk_deframer.sv */
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata (byte), s_tlast (chunk end)
// m_        out        m_tvalid / m_tready  m_tdata (record), m_tuser (kind),
//                                           m_tlast (final record of a byte)
//
// One byte is taken per cycle. Records leave through a registered output
// stage at one per cycle while m_tready is high; a byte that closes a packet
// and a chunk at once yields two records, sent one after the other and
// absorbed by a four-entry queue between the parser and the output stage.
// The input is stalled only while that queue is full. Reset (aresetn,
// synchronous, active low) clears the parser to await the first byte of a
// packet and empties the queue and output stage.
module rtp_rtcp_chunk_deframer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] data_byte
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] timestamp, [47:32] seq_number, [48] marker_bit,
    // [80:49] report_count, [99:81] packet_bytes, [103:100] zero
    output logic [103:0] m_tdata,
    // [2:0] kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import rrcd_pkg::*;

    logic   q_full;
    logic   push;
    entry_t push_data;
    logic   q_valid;
    logic   q_pop;
    entry_t q_data;
    rec_t   rec;

    // The parser tracks the position within the current packet and collects
    // header fields as they stream past.
    rrcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rrcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // The output stage splits each queue entry into its packet record and
    // end record, one transfer each.
    rrcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_rec    (rec),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'd0, rec.packet_bytes, rec.report_count, rec.marker_bit,
                      rec.seq_number, rec.timestamp};
    assign m_tuser = rec.kind;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import rrcd_pkg::*;

    // One byte of a chunk as the sender presents it.
    typedef struct {
        logic [7:0] data;
        logic       fin;
    } chunk_byte_t;

    // One record as the deframer should emit it.
    typedef struct {
        kind_t       kind;
        logic [31:0] stamp;
        logic [15:0] seq;
        logic        mark;
        logic [31:0] count;
        logic [18:0] nbytes;
        logic        fin;
    } deframe_rec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    rtp_rtcp_chunk_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Bytes waiting to be offered, and records the deframer still owes us.
    chunk_byte_t  chunk_bytes[$];
    deframe_rec_t pending_records[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned fail_count = 0;

    // Percent of cycles in which the sender holds off and the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Shadow of the parser state. The first byte of a packet is not kept,
    // since nothing in any record depends on it.
    logic [17:0] pos = '0;
    pclass_t     cls = CLS_AWAIT;
    logic [31:0] stamp_acc = '0;
    logic [15:0] seq_acc = '0;
    logic        mark_hold = 1'b0;
    logic [31:0] count_acc = '0;
    logic [15:0] rtcp_len = '0;
    logic [31:0] chunk_rtp_stamp = '0;
    logic [15:0] chunk_rtp_seq = '0;
    logic        drop_rest = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic deframe_rec_t make_rec(kind_t kind, logic [31:0] stamp,
                                              logic [15:0] seq, logic mark,
                                              logic [31:0] count,
                                              logic [18:0] nbytes);
        deframe_rec_t r;
        r.kind   = kind;
        r.stamp  = stamp;
        r.seq    = seq;
        r.mark   = mark;
        r.count  = count;
        r.nbytes = nbytes;
        r.fin    = 1'b0;
        return r;
    endfunction

    // Advances the shadow parser by one accepted byte and queues the records
    // that byte must produce, with the final one of them flagged.
    task automatic deframe_byte(input logic [7:0] b, input logic chunk_end);
        deframe_rec_t recs[$];
        deframe_rec_t r;
        logic [18:0]  used;
        logic [18:0]  frame_len;
        bit           closed;
        used = {1'b0, pos} + 19'd1;
        closed = 1'b0;
        if (!drop_rest) begin
            if (pos == 18'd0) begin
                // Start of a packet: all header fields restart from zero.
                stamp_acc = '0;
                seq_acc = '0;
                mark_hold = 1'b0;
                count_acc = '0;
                rtcp_len = '0;
                cls = CLS_AWAIT;
                // A chunk that stops after one byte never shows its type: report unknown.
                if (chunk_end) begin
                    recs.insert(recs.size(),
                                make_rec(KIND_UNKNOWN, '0, '0, 1'b0, '0, 19'd1));
                end else begin
                    pos = 18'd1;
                end
            end else if (pos == 18'd1 && b[6:0] != RTP_PAYLOAD_TYPE
                         && b != RTCP_SR_TYPE) begin
                // Unknown type: report it and ignore the rest of the chunk.
                recs.insert(recs.size(),
                            make_rec(KIND_UNKNOWN, '0, '0, 1'b0, '0, 19'd2));
                pos = '0;
                cls = CLS_AWAIT;
                drop_rest = 1'b1;
            end else begin
                if (pos == 18'd1) begin
                    if (b[6:0] == RTP_PAYLOAD_TYPE) begin
                        cls = CLS_RTP;
                        mark_hold = b[7];
                    end else begin
                        cls = CLS_RTCP;
                    end
                end else if (cls == CLS_RTP) begin
                    if (pos == 18'd2 || pos == 18'd3) begin
                        seq_acc = {seq_acc[7:0], b};
                    end else if (pos >= 18'd4 && pos <= 18'd7) begin
                        stamp_acc = {stamp_acc[23:0], b};
                    end
                end else begin
                    if (pos == 18'd2 || pos == 18'd3) begin
                        rtcp_len = {rtcp_len[7:0], b};
                    end else if (pos >= 18'd16 && pos <= 18'd19) begin
                        stamp_acc = {stamp_acc[23:0], b};
                    end else if (pos >= 18'd20 && pos <= 18'd23) begin
                        count_acc = {count_acc[23:0], b};
                    end
                end

                if (cls == CLS_RTP) begin
                    if (used == 19'(MAX_RTP_BYTES) || chunk_end) begin
                        recs.insert(recs.size(),
                                    make_rec(KIND_RTP, stamp_acc, seq_acc,
                                             mark_hold, '0, used));
                        chunk_rtp_stamp = stamp_acc;
                        chunk_rtp_seq = seq_acc;
                        closed = 1'b1;
                    end
                end else begin
                    frame_len = (19'(rtcp_len) + 19'd1) << 2;
                    if (pos >= 18'd3 && used == frame_len) begin
                        recs.insert(recs.size(),
                                    make_rec(KIND_RTCP, stamp_acc, '0, 1'b0,
                                             count_acc, used));
                        closed = 1'b1;
                    end else if (chunk_end) begin
                        // RTCP cut short by the chunk end.
                        recs.insert(recs.size(),
                                    make_rec(KIND_TRUNC, stamp_acc, '0, 1'b0,
                                             count_acc, used));
                        closed = 1'b1;
                    end
                end
                if (closed) begin
                    pos = '0;
                    cls = CLS_AWAIT;
                end else begin
                    pos = pos + 18'd1;
                end
            end
        end

        // The end record reports the chunk's last RTP packet, or zeros.
        if (chunk_end) begin
            recs.insert(recs.size(),
                        make_rec(KIND_END, chunk_rtp_stamp, chunk_rtp_seq,
                                 1'b0, '0, '0));
            chunk_rtp_stamp = '0;
            chunk_rtp_seq = '0;
            drop_rest = 1'b0;
            pos = '0;
            cls = CLS_AWAIT;
        end

        if (recs.size() > 0) begin
            recs[recs.size() - 1].fin = 1'b1;
        end
        foreach (recs[i]) begin
            r = recs[i];
            pending_records.insert(pending_records.size(), r);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic chunk_end);
        chunk_byte_t c;
        c.data = b;
        c.fin = chunk_end;
        chunk_bytes.insert(chunk_bytes.size(), c);
        bytes_queued++;
    endtask

    // RTP packet of len bytes; only byte 1 is forced to the RTP type.
    task automatic put_rtp(input int len, input bit close_chunk);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 1) begin
                b = {1'($urandom), RTP_PAYLOAD_TYPE};
            end
            push_byte(b, close_chunk && (i == len - 1));
        end
    endtask

    // RTCP packet with the given length field, of which len bytes are sent.
    task automatic put_rtcp(input logic [15:0] rlen, input int len,
                            input bit close_chunk);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (i)
                1:       b = RTCP_SR_TYPE;
                2:       b = rlen[15:8];
                3:       b = rlen[7:0];
                default: b = 8'($urandom);
            endcase
            push_byte(b, close_chunk && (i == len - 1));
        end
    endtask

    // Mostly well-formed chunks: complete RTCP packets, then a closing packet
    // of some kind. The rest is truncated RTCP, unknown types and plain noise.
    task automatic put_random_chunk();
        int          n_rtcp;
        int          rlen;
        int          full;
        int          take;
        logic [7:0]  b;
        n_rtcp = $urandom_range(0, 3);
        for (int i = 0; i < n_rtcp; i++) begin
            rlen = $urandom_range(0, 8);
            put_rtcp(16'(rlen), (rlen + 1) * 4, 1'b0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                put_rtp($urandom_range(1, 40), 1'b1);
            end
            4, 5: begin
                rlen = $urandom_range(0, 8);
                put_rtcp(16'(rlen), (rlen + 1) * 4, 1'b1);
            end
            6: begin
                rlen = $urandom_range(0, 65535);
                full = (rlen + 1) * 4;
                take = $urandom_range(1, (full - 1 < 40) ? full - 1 : 40);
                put_rtcp(16'(rlen), take, 1'b1);
            end
            7: begin
                push_byte(8'($urandom), 1'b0);
                do begin
                    b = 8'($urandom);
                end while (b[6:0] == RTP_PAYLOAD_TYPE || b == RTCP_SR_TYPE);
                take = $urandom_range(0, 10);
                push_byte(b, take == 0);
                for (int i = 0; i < take; i++) begin
                    push_byte(8'($urandom), i == take - 1);
                end
            end
            8: begin
                take = $urandom_range(1, 12);
                for (int i = 0; i < take; i++) begin
                    push_byte(8'($urandom), i == take - 1);
                end
            end
            default: begin
                put_rtcp(16'd0, 4, 1'b1);
            end
        endcase
    endtask

    task automatic put_random_chunks(input int unsigned target);
        int unsigned start;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            put_random_chunk();
        end
    endtask

    // Holds the sender back until every byte is taken and every record seen.
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || pending_records.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: a new byte is offered only once the previous transfer is done,
    // so s_tvalid gets at most one assignment per edge.
    always @(posedge aclk) begin : drive_proc
        chunk_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (chunk_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = chunk_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: every record transfer is matched against the oldest
    // outstanding prediction, field by field.
    always @(posedge aclk) begin : check_proc
        deframe_rec_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_records.size() == 0) begin
                    $error("record of kind %0d with none expected", m_tuser);
                    fail_count++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_tuser));
                    check_field("timestamp", 64'(want.stamp), 64'(m_tdata[31:0]));
                    check_field("seq_number", 64'(want.seq), 64'(m_tdata[47:32]));
                    check_field("marker_bit", 64'(want.mark), 64'(m_tdata[48]));
                    check_field("report_count", 64'(want.count),
                                64'(m_tdata[80:49]));
                    check_field("packet_bytes", 64'(want.nbytes),
                                64'(m_tdata[99:81]));
                    check_field("tdata padding", 64'd0, 64'(m_tdata[103:100]));
                    check_field("last", 64'(want.fin), 64'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles now and then, receiver stalls a lot.
        send_idle_pct = 26;
        recv_stall_pct = 72;

        // Lone byte: its type never shows, so unknown type then end record.
        push_byte(8'hFF, 1'b1);
        // Unknown type; the byte after it is dropped.
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h55, 1'b1);
        // RTP with marker and every header field at all ones.
        push_byte(8'h80, 1'b0);
        push_byte({1'b1, RTP_PAYLOAD_TYPE}, 1'b0);
        for (int i = 0; i < 6; i++) begin
            push_byte(8'hFF, i == 5);
        end
        // Shortest RTCP closes with the chunk: two records from one byte,
        // and the end record carries zeros as no RTP came.
        push_byte(8'h00, 1'b0);
        push_byte(RTCP_SR_TYPE, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // RTCP cut off right after its type byte.
        push_byte(8'h80, 1'b0);
        push_byte(RTCP_SR_TYPE, 1'b1);
        // RTP cut off right after its type byte, marker clear.
        push_byte(8'h80, 1'b0);
        push_byte({1'b0, RTP_PAYLOAD_TYPE}, 1'b1);

        // RTCP long enough to carry its timestamp and count.
        put_rtcp(16'd5, 24, 1'b1);

        put_random_chunks(180);
        wait_drained();

        // Phase two: the roles swap.
        send_idle_pct = 72;
        recv_stall_pct = 26;
        put_random_chunks(180);
        wait_drained();

        // Phase three: full rate both ways.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        put_random_chunks(90);
        put_random_chunks(90);
        wait_drained();

        // Give a stray extra record time to show up.
        repeat (20) @(posedge aclk);
        if (pending_records.size() != 0) begin
            $error("%0d records never arrived", pending_records.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
